// ----- sv/mlpsc_pkg.sv -----
// Package with weights, biases and widths for the sensor classifier.
`default_nettype none
package mlpsc_pkg;
    localparam int NIn  = 4;
    localparam int NH1  = 8;
    localparam int NH2  = 8;
    localparam int NOut = 3;

    // Layer 1 sum: |x|<=128, weights up to 462 abs total -> fits in 18 bits.
    localparam int L1W = 18;
    // Layer 2 sum: h1 < 2^17, weights sum < 1024 -> under 2^27.
    localparam int L2W = 29;
    // Layer 3 sum: h2 < 2^27, weight 384*8 -> under 2^39.
    localparam int L3W = 42;

    typedef logic signed [7:0]     sample_t;
    typedef logic signed [L1W-1:0] l1_t;
    typedef logic signed [L2W-1:0] l2_t;
    typedef logic signed [L3W-1:0] l3_t;

    typedef sample_t vec_in_t [NIn];
    typedef l1_t     vec_h1_t [NH1];
    typedef l2_t     vec_h2_t [NH2];
    typedef l3_t     vec_out_t [NOut];

    function automatic logic signed [9:0] w1(input int j, input int i);
        logic signed [9:0] r;
        r = 10'sd26;
        if (i == (j % 4)) r = ((j == 2) || (j == 3) || (j == 4) || (j == 5))
            ? -10'sd384 : 10'sd384;
        return r;
    endfunction

    localparam logic signed [8:0] W2ROW [8] = '{9'sd205, 9'sd102, 9'sd154, 9'sd77,
                                               9'sd102, 9'sd77, 9'sd77, 9'sd51};

    // Layer 2 is a permuted row of the same eight values.
    function automatic logic signed [8:0] w2(input int j, input int i);
        int k;
        k = (j ^ i);
        return W2ROW[k];
    endfunction

    localparam logic signed [9:0] W3 [3] = '{-10'sd307, 10'sd256, 10'sd384};

    localparam l1_t B1 = -l1_t'(77 * 127);
    localparam l2_t B2 = -l2_t'(102 * 127 * 256);
    localparam l3_t B3 [3] = '{l3_t'(64'sd307 * 127 * 65536),
                               -l3_t'(64'sd205 * 127 * 65536),
                               -l3_t'(64'sd640 * 127 * 65536)};
endpackage
`default_nettype wire

// ----- sv/mlpsc_cell.sv -----
// One pipeline cell: holds a valid bit and a payload and hands them on.
`default_nettype none
module mlpsc_cell #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         adv,
    input  wire logic         in_valid,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    output logic [W-1:0]      out_data
);
    logic         valid_reg;
    logic [W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

// ----- sv/mlp_sensor_classifier_unit.sv -----
// Top level of the 4-8-8-3 perceptron sensor classifier.
// Channels: s_valid/s_ready carry four signed 8-bit samples; m_valid/m_ready
// return the 2-bit class (0 normal, 1 alert, 2 critical, ties to lower).
// The block is a chain of four cells: layer 1 with ReLU, layer 2 with ReLU,
// layer 3, then argmax into the output register.
// A transfer is registered in the layer 1, layer 2, layer 3 and output cells in turn before m_valid.
// Throughput is one item per cycle; the chain advances whenever the output
// register is empty or being taken, so back-to-back transfers flow with no
// gap as long as the receiver keeps m_ready high.
// When m_ready is low and the output cell holds a result, the whole chain
// holds and s_ready drops.
// Reset clears all valid bits; no results are pending after reset.
`default_nettype none
module mlp_sensor_classifier_unit
    import mlpsc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_temp_sample,
    input  wire logic [7:0] s_humidity_sample,
    input  wire logic [7:0] s_pressure_sample,
    input  wire logic [7:0] s_light_sample,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_class_index
);
    logic adv;
    logic v1, v2, v3;
    logic [NH1*L1W-1:0] d1_in, d1;
    logic [NH2*L2W-1:0] d2_in, d2;
    logic [NOut*L3W-1:0] d3_in, d3;
    logic [1:0] cls_in;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_comb begin
        sample_t x [NIn];
        logic signed [L1W-1:0] acc;
        x[0] = s_temp_sample;
        x[1] = s_humidity_sample;
        x[2] = s_pressure_sample;
        x[3] = s_light_sample;
        for (int j = 0; j < NH1; j++) begin
            acc = B1;
            for (int i = 0; i < NIn; i++) begin
                acc = acc + (l1_t'(w1(j, i)) * l1_t'(x[i]));
            end
            d1_in[j*L1W +: L1W] = acc[L1W-1] ? '0 : acc;
        end
    end

    mlpsc_cell #(.W(NH1*L1W)) u_l1 (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(s_valid), .in_data(d1_in), .out_valid(v1), .out_data(d1));

    always_comb begin
        logic signed [L2W-1:0] acc;
        logic signed [L1W:0]   h;
        for (int j = 0; j < NH2; j++) begin
            acc = B2;
            for (int i = 0; i < NH1; i++) begin
                h = {1'b0, d1[i*L1W +: L1W]};
                acc = acc + (l2_t'(w2(j, i)) * l2_t'(h));
            end
            d2_in[j*L2W +: L2W] = acc[L2W-1] ? '0 : acc;
        end
    end

    mlpsc_cell #(.W(NH2*L2W)) u_l2 (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(v1), .in_data(d2_in), .out_valid(v2), .out_data(d2));

    // Output weights are uniform per class, so each class scales one sum.
    always_comb begin
        logic signed [L2W+3:0] s;
        s = '0;
        for (int i = 0; i < NH2; i++) begin
            s = s + (L2W+4)'($signed({1'b0, d2[i*L2W +: L2W]}));
        end
        for (int j = 0; j < NOut; j++) begin
            d3_in[j*L3W +: L3W] = B3[j] + (l3_t'(W3[j]) * l3_t'(s));
        end
    end

    mlpsc_cell #(.W(NOut*L3W)) u_l3 (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(v2), .in_data(d3_in), .out_valid(v3), .out_data(d3));

    always_comb begin
        l3_t y0, y1, y2, best;
        y0 = d3[0 +: L3W];
        y1 = d3[L3W +: L3W];
        y2 = d3[2*L3W +: L3W];
        best = y0;
        cls_in = 2'd0;
        if (y1 > best) begin
            best = y1;
            cls_in = 2'd1;
        end
        if (y2 > best) begin
            cls_in = 2'd2;
        end
    end

    mlpsc_cell #(.W(2)) u_out (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(v3), .in_data(cls_in), .out_valid(m_valid), .out_data(m_class_index));

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_class_index))
        else $error("result changed while stalled");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_class_index != 2'd3)
        else $error("class index out of range");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && v3 |=> m_valid)
        else $error("result lost at output cell");
endmodule
`default_nettype wire

// ----- bench/tb_mlp_sensor_classifier_unit.sv -----
// Testbench for the sensor classifier: random and directed vectors checked against a predictor.
`default_nettype none

class class_scoreboard;
    logic [1:0] pending_class[$];
    int         fail_count;

    function new();
        fail_count = 0;
    endfunction

    // Fixed-point 4-8-8-3 network with ReLU hidden layers and argmax.
    static function logic [1:0] classify(input logic signed [7:0] t, input logic signed [7:0] h,
                                         input logic signed [7:0] p, input logic signed [7:0] l);
        longint x[4];
        longint h1[8];
        longint h2[8];
        longint y[3];
        longint acc;
        longint wa;
        longint w2row[8];
        longint w3[3];
        longint b3[3];
        logic [1:0] best;
        x[0] = t; x[1] = h; x[2] = p; x[3] = l;
        w2row = '{205, 102, 154, 77, 102, 77, 77, 51};
        w3 = '{-307, 256, 384};
        b3 = '{307, -205, -640};
        for (int j = 0; j < 8; j++) begin
            acc = -77 * 127;
            for (int i = 0; i < 4; i++) begin
                wa = 26;
                if (i == j % 4) wa = (j >= 2 && j <= 5) ? -384 : 384;
                acc += wa * x[i];
            end
            h1[j] = acc > 0 ? acc : 0;
        end
        for (int j = 0; j < 8; j++) begin
            acc = -102 * 127 * 256;
            for (int i = 0; i < 8; i++) acc += w2row[j ^ i] * h1[i];
            h2[j] = acc > 0 ? acc : 0;
        end
        for (int j = 0; j < 3; j++) begin
            acc = b3[j] * 127 * 65536;
            for (int i = 0; i < 8; i++) acc += w3[j] * h2[i];
            y[j] = acc;
        end
        best = 0;
        for (int j = 1; j < 3; j++) if (y[j] > y[best]) best = j[1:0];
        return best;
    endfunction

    function void note_input(input logic [7:0] t, input logic [7:0] h,
                             input logic [7:0] p, input logic [7:0] l);
        pending_class.push_back(classify(t, h, p, l));
    endfunction

    function void check_result(input logic [1:0] got);
        logic [1:0] want;
        if (pending_class.size() == 0) begin
            $error("class_index: no result expected, got %0d", got);
            fail_count++;
        end else begin
            want = pending_class.pop_front();
            if (got !== want) begin
                $error("class_index: expected %0d, actual %0d", want, got);
                fail_count++;
            end
        end
    endfunction
endclass

module tb_mlp_sensor_classifier_unit;
    import mlpsc_pkg::*;

    localparam int NumRandom = 1350;
    localparam int CycleLimit = 200000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_temp_sample;
    logic [7:0] s_humidity_sample;
    logic [7:0] s_pressure_sample;
    logic [7:0] s_light_sample;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_class_index;

    class_scoreboard board;
    bit  calm_phase;
    int  cycle_count;

    mlp_sensor_classifier_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_temp_sample(s_temp_sample), .s_humidity_sample(s_humidity_sample),
        .s_pressure_sample(s_pressure_sample), .s_light_sample(s_light_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_class_index(m_class_index)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        board = new();
        calm_phase = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_temp_sample = '0;
        s_humidity_sample = '0;
        s_pressure_sample = '0;
        s_light_sample = '0;
    end

    // Offers one vector and holds it until the transfer happens.
    task automatic send_vector(input logic [7:0] t, input logic [7:0] h,
                               input logic [7:0] p, input logic [7:0] l);
        int gap;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_temp_sample <= t;
        s_humidity_sample <= h;
        s_pressure_sample <= p;
        s_light_sample <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(t, h, p, l);
    endtask

    task automatic send_random;
        logic [7:0] v[4];
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 5))
                0: v[k] = 8'h80;
                1: v[k] = 8'h7f;
                2: v[k] = 8'($urandom_range(0, 8) - 4);
                default: v[k] = 8'($urandom);
            endcase
        end
        send_vector(v[0], v[1], v[2], v[3]);
    endtask

    // Receiver: stalls in bursts, checks each result transfer.
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm_phase && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 12);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            if (m_valid && m_ready) board.check_result(m_class_index);
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CycleLimit) begin
                $display("** mlp_sensor_classifier_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] ext[4];
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, zeros, ones, single-sensor spikes.
        ext = '{8'h80, 8'h7f, 8'h00, 8'hff};
        for (int k = 0; k < 4; k++) send_vector(ext[k], ext[k], ext[k], ext[k]);
        for (int k = 0; k < 4; k++) begin
            send_vector(k == 0 ? 8'h7f : 8'h00, k == 1 ? 8'h7f : 8'h00,
                        k == 2 ? 8'h7f : 8'h00, k == 3 ? 8'h7f : 8'h00);
            send_vector(k == 0 ? 8'h80 : 8'h00, k == 1 ? 8'h80 : 8'h00,
                        k == 2 ? 8'h80 : 8'h00, k == 3 ? 8'h80 : 8'h00);
        end
        send_vector(8'h7f, 8'h7f, 8'h80, 8'h80);
        send_vector(8'h80, 8'h80, 8'h7f, 8'h7f);
        send_vector(8'h55, 8'haa, 8'h55, 8'haa);

        for (int n = 0; n < NumRandom; n++) begin
            // Once midway the sender waits for the pipeline to drain.
            if (n == NumRandom / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (board.pending_class.size() != 0) @(posedge aclk);
            end
            if (n == NumRandom - 200) calm_phase = 1'b1;
            send_random();
        end
        s_valid <= 1'b0;

        while (board.pending_class.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (board.fail_count == 0) begin
            $display("** mlp_sensor_classifier_unit: PASSED **");
        end else begin
            $display("** mlp_sensor_classifier_unit: FAILED **");
        end
        $finish;
    end
endmodule

`default_nettype wire
